[src/hrlp_pkg.sv]
`default_nettype none

package hrlp_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_METHOD  = 2'd1,
		ST_URI     = 2'd2,
		ST_VERSION = 2'd3
	} status_t;

	// method codes
	typedef enum logic [3:0] {
		M_NONE    = 4'd0,
		M_OPTIONS = 4'd1,
		M_GET     = 4'd2,
		M_HEAD    = 4'd3,
		M_POST    = 4'd4,
		M_PUT     = 4'd5,
		M_DELETE  = 4'd6,
		M_TRACE   = 4'd7,
		M_CONNECT = 4'd8
	} method_t;

	localparam int URI_LEN_WIDTH = 16;

	// one parsed request line
	typedef struct packed {
		status_t                   status;
		method_t                   method;
		logic [3:0]                uri_start;
		logic [URI_LEN_WIDTH-1:0]  uri_length;
		logic [3:0]                major_ver;
		logic [3:0]                minor_ver;
	} result_t;

	// number of letters in the method name
	function automatic logic [3:0] method_len(input method_t m);
		logic [3:0] len;
		case (m)
			M_OPTIONS: len = 4'd7;
			M_GET:     len = 4'd3;
			M_HEAD:    len = 4'd4;
			M_POST:    len = 4'd4;
			M_PUT:     len = 4'd3;
			M_DELETE:  len = 4'd6;
			M_TRACE:   len = 4'd5;
			M_CONNECT: len = 4'd7;
			default:   len = 4'd0;
		endcase
		return len;
	endfunction

	// expected upper-case letter of the method name at a position
	function automatic logic [7:0] method_char(input method_t m, input logic [2:0] pos);
		logic [63:0] txt;
		case (m)
			M_OPTIONS: txt = "OPTIONS ";
			M_GET:     txt = "GET     ";
			M_HEAD:    txt = "HEAD    ";
			M_POST:    txt = "POST    ";
			M_PUT:     txt = "PUT     ";
			M_DELETE:  txt = "DELETE  ";
			M_TRACE:   txt = "TRACE   ";
			M_CONNECT: txt = "CONNECT ";
			default:   txt = "        ";
		endcase
		return txt[8*(7-int'(pos)) +: 8];
	endfunction

	// ascii letter folding
	function automatic logic [7:0] to_upper(input logic [7:0] b);
		return (b >= "a" && b <= "z") ? b - 8'd32 : b;
	endfunction

endpackage

`default_nettype wire

[src/hrlp_fsm.sv]
`default_nettype none

module hrlp_fsm
	import hrlp_pkg::*;
#(
	parameter int URI_COUNT_WIDTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] line_byte,
	input  wire logic       first,
	output logic            fire,
	output result_t         res
);

	typedef enum logic [2:0] {
		PH_M_FIRST,
		PH_M_SECOND,
		PH_M_REST,
		PH_SPACE,
		PH_URI_FIRST,
		PH_URI,
		PH_VERSION,
		PH_DONE
	} phase_t;

	phase_t                     phase_q, cur_phase, nxt_phase;
	method_t                    method_q, cur_method, nxt_method;
	logic [3:0]                 pos_q, cur_pos, nxt_pos;
	logic [URI_COUNT_WIDTH-1:0] cnt_q, cur_cnt, nxt_cnt;
	logic [3:0]                 major_q, cur_major, nxt_major;
	logic [3:0]                 minor_q, cur_minor, nxt_minor;
	logic [7:0]                 up;
	logic                       byte_num;
	status_t                    st;
	logic [URI_LEN_WIDTH-1:0]   uri_len;

	// restart on first flag
	always_comb begin
		cur_phase  = first ? PH_M_FIRST : phase_q;
		cur_method = first ? M_NONE : method_q;
		cur_pos    = first ? 4'd0 : pos_q;
		cur_cnt    = first ? '0 : cnt_q;
		cur_major  = first ? 4'd0 : major_q;
		cur_minor  = first ? 4'd0 : minor_q;
	end

	assign up       = to_upper(line_byte);
	assign byte_num = (line_byte >= "0") && (line_byte <= "9");

	// next state and result for one byte
	always_comb begin
		nxt_phase  = cur_phase;
		nxt_method = cur_method;
		nxt_pos    = cur_pos;
		nxt_cnt    = cur_cnt;
		nxt_major  = cur_major;
		nxt_minor  = cur_minor;
		fire       = 1'b0;
		st         = ST_OK;
		case (cur_phase)
			PH_M_FIRST: begin
				nxt_pos   = 4'd1;
				nxt_phase = PH_M_REST;
				case (up)
					"O": nxt_method = M_OPTIONS;
					"G": nxt_method = M_GET;
					"H": nxt_method = M_HEAD;
					"D": nxt_method = M_DELETE;
					"T": nxt_method = M_TRACE;
					"C": nxt_method = M_CONNECT;
					"P": begin
						nxt_pos   = cur_pos;
						nxt_phase = PH_M_SECOND;
					end
					default: begin
						fire       = 1'b1;
						st         = ST_METHOD;
						nxt_method = M_NONE;
						nxt_cnt    = '0;
						nxt_pos    = cur_pos;
						nxt_phase  = PH_DONE;
					end
				endcase
			end
			PH_M_SECOND: begin
				nxt_pos   = 4'd2;
				nxt_phase = PH_M_REST;
				if (up == "O") begin
					nxt_method = M_POST;
				end else if (up == "U") begin
					nxt_method = M_PUT;
				end else begin
					fire       = 1'b1;
					st         = ST_METHOD;
					nxt_method = M_NONE;
					nxt_cnt    = '0;
					nxt_pos    = cur_pos;
					nxt_phase  = PH_DONE;
				end
			end
			PH_M_REST: begin
				if (cur_pos >= method_len(cur_method) ||
				    up != method_char(cur_method, cur_pos[2:0])) begin
					fire       = 1'b1;
					st         = ST_METHOD;
					nxt_method = M_NONE;
					nxt_cnt    = '0;
					nxt_phase  = PH_DONE;
				end else begin
					nxt_pos = cur_pos + 4'd1;
					if (cur_pos + 4'd1 >= method_len(cur_method)) begin
						nxt_phase = PH_SPACE;
					end
				end
			end
			PH_SPACE: begin
				if (line_byte != " ") begin
					fire      = 1'b1;
					st        = ST_URI;
					nxt_phase = PH_DONE;
				end else begin
					nxt_phase = PH_URI_FIRST;
				end
			end
			PH_URI_FIRST: begin
				if (line_byte == " " || line_byte == 8'd0) begin
					fire      = 1'b1;
					st        = ST_URI;
					nxt_phase = PH_DONE;
				end else begin
					nxt_cnt   = URI_COUNT_WIDTH'(1);
					nxt_phase = PH_URI;
				end
			end
			PH_URI: begin
				if (line_byte == 8'd0) begin
					fire      = 1'b1;
					st        = ST_VERSION;
					nxt_phase = PH_DONE;
				end else if (line_byte == " ") begin
					nxt_pos   = 4'd0;
					nxt_phase = PH_VERSION;
				end else if (!(&cur_cnt)) begin
					nxt_cnt = cur_cnt + URI_COUNT_WIDTH'(1);
				end
			end
			PH_VERSION: begin
				nxt_pos = cur_pos + 4'd1;
				fire    = 1'b1;
				st      = ST_VERSION;
				case (cur_pos)
					4'd0: fire = (line_byte != "H");
					4'd1: fire = (line_byte != "T");
					4'd2: fire = (line_byte != "T");
					4'd3: fire = (line_byte != "P");
					4'd4: fire = (line_byte != "/");
					4'd5: begin
						fire      = !byte_num;
						nxt_major = line_byte[3:0];
					end
					4'd6: fire = (line_byte != ".");
					4'd7: begin
						fire      = !byte_num;
						nxt_minor = line_byte[3:0];
					end
					4'd8: fire = (line_byte != 8'h0d);
					4'd9: begin
						if (line_byte == 8'h0a) begin
							st = ST_OK;
						end
					end
					default: fire = 1'b1;
				endcase
				if (fire) begin
					nxt_phase = PH_DONE;
					nxt_pos   = cur_pos;
					nxt_major = cur_major;
					nxt_minor = cur_minor;
				end
			end
			default: begin
				nxt_phase = PH_DONE;
			end
		endcase
	end

	// uri length saturates at the field width when the counter is wider, else is zero-extended
	generate
		if (URI_COUNT_WIDTH > URI_LEN_WIDTH) begin : g_sat
			assign uri_len = (|nxt_cnt[URI_COUNT_WIDTH-1:URI_LEN_WIDTH]) ?
				'1 : nxt_cnt[URI_LEN_WIDTH-1:0];
		end else begin : g_ext
			assign uri_len = URI_LEN_WIDTH'(nxt_cnt);
		end
	endgenerate

	// result fields
	always_comb begin
		res.status     = st;
		res.method     = nxt_method;
		res.uri_start  = (nxt_method != M_NONE) ? method_len(nxt_method) + 4'd1 : 4'd0;
		res.uri_length = uri_len;
		res.major_ver  = (st == ST_OK) ? cur_major : 4'd0;
		res.minor_ver  = (st == ST_OK) ? cur_minor : 4'd0;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_M_FIRST;
			method_q <= M_NONE;
			pos_q    <= 4'd0;
			cnt_q    <= '0;
			major_q  <= 4'd0;
			minor_q  <= 4'd0;
		end else if (step) begin
			phase_q  <= nxt_phase;
			method_q <= nxt_method;
			pos_q    <= nxt_pos;
			cnt_q    <= nxt_cnt;
			major_q  <= nxt_major;
			minor_q  <= nxt_minor;
		end
	end

endmodule

`default_nettype wire

[src/http_request_line_parser_core.sv]
// HTTP request line parser.
// Input channel: one byte of a request line per transaction (line_byte),
// with first set on the opening byte of each new line; line_valid/line_stall.
// Output channel: one result transaction per line (status, method, uri
// offset and length, version digits), issued at the closing LF or at the
// first error; result_valid/result_stall. Bytes after a result are dropped
// until the next byte flagged first.
// Throughput: one byte per cycle while no held result stalls, set by the
// byte-wide state machine between the input register and result register.
// Path: the byte that ends the line is held in the input register, and its
// result is written to the result register when that register can take it.
// Reset: clears both registers' valid flags and puts the parser in the
// state awaiting the first method byte, so a missing first flag after
// reset behaves as a set one.
// Stall: a stalled result is held; the input register still drains into
// the result register as it empties, and line_stall rises only while the
// input register holds a byte and a full result register is stalled.
`default_nettype none

module http_request_line_parser_core
	import hrlp_pkg::*;
#(
	parameter int URI_COUNT_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        line_valid,
	output logic             line_stall,
	input  wire logic [7:0]  line_byte,
	input  wire logic        first,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       status,
	output logic [3:0]       method,
	output logic [3:0]       uri_start,
	output logic [15:0]      uri_length,
	output logic [3:0]       major_ver,
	output logic [3:0]       minor_ver
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       adv;
	logic       step;
	logic       fire;
	result_t    res;
	logic       res_valid_q;
	result_t    res_q;

	// input register moves on when the result register can take a result
	assign adv        = !res_valid_q || !result_stall;
	assign line_stall = valid_s1 && !adv;
	assign step       = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!line_stall) begin
			valid_s1 <= line_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line_valid && !line_stall) begin
			byte_s1  <= line_byte;
			first_s1 <= first;
		end
	end

	hrlp_fsm #(
		.URI_COUNT_WIDTH(URI_COUNT_WIDTH)
	) u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.line_byte(byte_s1),
		.first    (first_s1),
		.fire     (fire),
		.res      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= step && fire;
		end
	end

	always_ff @(posedge clk) begin
		if (step && fire) begin
			res_q <= res;
		end
	end

	assign result_valid = res_valid_q;
	assign status       = res_q.status;
	assign method       = res_q.method;
	assign uri_start    = res_q.uri_start;
	assign uri_length   = res_q.uri_length;
	assign major_ver    = res_q.major_ver;
	assign minor_ver    = res_q.minor_ver;

`ifndef SYNTHESIS
	// input only backs up behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		line_stall |-> (valid_s1 && res_valid_q && result_stall))
		else $error("input stalled without a held result");

	// a good line always names a method
	a_ok_method: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == ST_OK) |-> (method != M_NONE && uri_start != 4'd0))
		else $error("ok result without a method");

	// unknown method carries no uri
	a_method_err: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == ST_METHOD) |->
		(method == M_NONE && uri_start == 4'd0 && uri_length == 16'd0))
		else $error("method error with uri fields set");

	// version digits only on a good line
	a_version_err: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != ST_OK) |->
		(major_ver == 4'd0 && minor_ver == 4'd0))
		else $error("version digits on an error result");
`endif

endmodule

`default_nettype wire
